/* sv/tps_pkg.sv */
// Package for the tick priority scheduler: payload structs, operation codes,
// sequencer states and size defaults. No dependencies.
package tps_pkg;

    localparam int unsigned NumTasksDefault = 8;
    localparam int unsigned NumSemsDefault  = 8;
    localparam int unsigned PrioWidth       = 8;
    localparam int unsigned PrioTasks       = 8;

    typedef enum logic [2:0] {
        OP_SCHEDULE = 3'd0,
        OP_SLEEP    = 3'd1,
        OP_P        = 3'd2,
        OP_V        = 3'd3,
        OP_INIT     = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [2:0]  sem_index;
        logic [15:0] amount;
    } cmd_t;

    typedef struct packed {
        logic [2:0] running_task;
        logic       no_task_ready;
        logic       caller_blocked;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OP,
        ST_VSHIFT,
        ST_DEC,
        ST_PICK1,
        ST_RELOAD,
        ST_PICK2,
        ST_DONE
    } state_t;

endpackage

/* sv/tick_priority_scheduler_with_semaphores.sv */
// Tick priority scheduler with counting semaphores, top level.
// Depends on tps_pkg (payload structs, op codes, sequencer states).
//
//  channel | signals                    | transfer
//  --------+----------------------------+-------------------------------
//  command | start, busy, cmd           | start high while busy low
//  result  | done, rsp                  | done high for one cycle
//  config  | cfg_valid, cfg_ready, cfg  | cfg_valid and cfg_ready high
//
// busy covers decode and result for a command with no schedule pass; a pass
// adds one shared-compare sweep over the tasks for decrement and one for pick,
// and a reload sweep plus a second pick when the first pick finds no budget.
// A V that wakes a task first shifts its queue one entry a cycle.
// The next command can be taken in the cycle after done. Reset clears all control
// state and loads every semaphore count with one. The receiver cannot stall.
module tick_priority_scheduler_with_semaphores #(
    parameter int unsigned NUM_TASKS      = tps_pkg::NumTasksDefault,
    parameter int unsigned NUM_SEMAPHORES = tps_pkg::NumSemsDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tps_pkg::cmd_t       cmd,
    output logic                done,
    output tps_pkg::rsp_t       rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [63:0]         cfg
);
    import tps_pkg::*;

    localparam int unsigned TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int unsigned SW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int unsigned QW = $clog2(NUM_TASKS + 1);
    localparam int unsigned QD = NUM_SEMAPHORES * NUM_TASKS;
    localparam int unsigned QAW = (QD > 1) ? $clog2(QD) : 1;

    // Task-side state: read at the sweep index only, so flops per task.
    logic [63:0]          prio_reg;
    logic [TW-1:0]        cur_reg, cur_next;
    logic [7:0]           budget_reg [NUM_TASKS];
    logic [15:0]          sleep_reg  [NUM_TASKS];
    logic [NUM_TASKS-1:0] wait_reg;
    logic signed [7:0]    sem_reg    [NUM_SEMAPHORES];
    logic [QW-1:0]        qlen_reg   [NUM_SEMAPHORES];

    // Wait queues: one memory, semaphore-major, one read and one write a cycle.
    logic [TW-1:0]        queue_mem [QD];
    logic [TW-1:0]        qrd_reg;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [TW-1:0]        idx_reg;      // sweep index
    logic [7:0]           top_reg;      // best budget in current pick
    logic [TW-1:0]        best_reg;
    logic                 idle_reg, blk_reg;
    logic [QW-1:0]        qi_reg;       // queue shift position

    logic [2:0]           op;
    logic [SW-1:0]        sidx;
    logic                 sem_ok;
    logic                 last;
    logic                 ready_t;
    logic [7:0]           prio_t;
    logic signed [7:0]    sem_new;
    logic [QAW-1:0]       qbase;

    assign op     = cmd_reg.operation;
    assign sidx   = SW'(cmd_reg.sem_index);
    assign sem_ok = 32'(cmd_reg.sem_index) < NUM_SEMAPHORES;
    assign last   = 32'(idx_reg) == NUM_TASKS - 1;
    assign ready_t = !wait_reg[idx_reg] && (sleep_reg[idx_reg] == 16'd0);
    assign prio_t = (32'(idx_reg) < PrioTasks) ? prio_reg[8*idx_reg +: 8] : 8'd0;
    assign qbase  = QAW'(32'(sidx) * NUM_TASKS);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);

    always_comb
    begin
        sem_new = sem_reg[sidx];
        if (op == OP_P && sem_reg[sidx] != -8'sd128)
            sem_new = sem_reg[sidx] - 8'sd1;
        else if (op == OP_V && sem_reg[sidx] != 8'sd127)
            sem_new = sem_reg[sidx] + 8'sd1;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_OP;
            ST_OP:
            begin
                priority if (op == OP_SCHEDULE || op == OP_SLEEP)
                    state_next = ST_DEC;
                else if (op == OP_P && sem_ok && sem_new < 0)
                    state_next = ST_DEC;
                else if (op == OP_V && sem_ok && sem_new <= 0 && qlen_reg[sidx] != '0)
                    state_next = ST_VSHIFT;
                else
                    state_next = ST_DONE;
            end
            ST_VSHIFT: if (qi_reg + QW'(1) >= qlen_reg[sidx]) state_next = ST_DEC;
            ST_DEC:    if (last) state_next = ST_PICK1;
            ST_PICK1:
                if (last)
                    state_next = (top_reg != 0 || (ready_t && budget_reg[idx_reg] != 0))
                                 ? ST_DONE : ST_RELOAD;
            ST_RELOAD: if (last) state_next = ST_PICK2;
            ST_PICK2:  if (last) state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Output decode.
    always_comb
    begin
        done = (state_reg == ST_DONE);
        rsp.running_task   = 3'(cur_reg);
        rsp.no_task_ready  = idle_reg;
        rsp.caller_blocked = blk_reg;
    end

    // Pick step: strict greater keeps lowest index on ties.
    logic       take;
    logic [7:0] top_cand;
    logic [TW-1:0] best_cand;
    always_comb
    begin
        take      = ready_t && (budget_reg[idx_reg] > top_reg);
        top_cand  = take ? budget_reg[idx_reg] : top_reg;
        best_cand = take ? idx_reg : best_reg;
        cur_next  = cur_reg;
        if (last && top_cand != 0)
            cur_next = best_cand;
    end

    // Queue shift: at shift position k the read register holds entry k,
    // which moves down to k-1.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            cmd_reg <= cmd;
        qrd_reg <= queue_mem[qbase + QAW'(qi_reg + ((state_reg == ST_VSHIFT) ? QW'(1) : QW'(0)))];
        if (state_reg == ST_OP && op == OP_P && sem_ok && sem_new < 0
            && 32'(qlen_reg[sidx]) < NUM_TASKS)
            queue_mem[qbase + QAW'(qlen_reg[sidx])] <= cur_reg;
        else if (state_reg == ST_VSHIFT && qi_reg != '0)
            queue_mem[qbase + QAW'(qi_reg - QW'(1))] <= qrd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            prio_reg  <= '0;
            cur_reg   <= '0;
            wait_reg  <= '0;
            idx_reg   <= '0;
            top_reg   <= '0;
            best_reg  <= '0;
            idle_reg  <= 1'b0;
            blk_reg   <= 1'b0;
            qi_reg    <= '0;
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                budget_reg[i] <= '0;
                sleep_reg[i]  <= '0;
            end
            for (int s = 0; s < NUM_SEMAPHORES; s++)
            begin
                sem_reg[s]  <= 8'sd1;
                qlen_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                prio_reg <= cfg;
            unique case (state_reg)
                ST_IDLE:
                begin
                    idx_reg  <= '0;
                    top_reg  <= '0;
                    best_reg <= '0;
                    qi_reg   <= '0;
                    idle_reg <= 1'b0;
                    blk_reg  <= 1'b0;
                end
                ST_OP:
                begin
                    if (op == OP_SLEEP)
                    begin
                        sleep_reg[cur_reg]  <= cmd_reg.amount;
                        budget_reg[cur_reg] <= '0;
                    end
                    else if (op == OP_INIT && sem_ok)
                        sem_reg[sidx] <= (cmd_reg.amount > 16'd127) ? 8'sd127
                                         : 8'(cmd_reg.amount);
                    else if ((op == OP_P || op == OP_V) && sem_ok)
                    begin
                        sem_reg[sidx] <= sem_new;
                        if (op == OP_P && sem_new < 0)
                        begin
                            wait_reg[cur_reg]   <= 1'b1;
                            budget_reg[cur_reg] <= '0;
                            blk_reg             <= 1'b1;
                            if (32'(qlen_reg[sidx]) < NUM_TASKS)
                                qlen_reg[sidx] <= qlen_reg[sidx] + QW'(1);
                        end
                    end
                end
                ST_VSHIFT:
                begin
                    // First cycle: qrd_reg holds the head entry.
                    if (qi_reg == '0)
                    begin
                        wait_reg[qrd_reg]   <= 1'b0;
                        budget_reg[qrd_reg] <= 8'd1;
                    end
                    qi_reg <= qi_reg + QW'(1);
                    if (qi_reg + QW'(1) >= qlen_reg[sidx])
                        qlen_reg[sidx] <= qlen_reg[sidx] - QW'(1);
                end
                ST_DEC:
                begin
                    if (sleep_reg[idx_reg] != 16'd0)
                        sleep_reg[idx_reg] <= sleep_reg[idx_reg] - 16'd1;
                    idx_reg <= last ? '0 : idx_reg + TW'(1);
                end
                ST_PICK1, ST_PICK2:
                begin
                    top_reg  <= last ? '0 : top_cand;
                    best_reg <= last ? '0 : best_cand;
                    cur_reg  <= cur_next;
                    idx_reg  <= last ? '0 : idx_reg + TW'(1);
                    if (state_reg == ST_PICK2 && last)
                        idle_reg <= (top_cand == 0);
                end
                ST_RELOAD:
                begin
                    if (ready_t)
                        budget_reg[idx_reg] <= prio_t;
                    idx_reg <= last ? '0 : idx_reg + TW'(1);
                end
                ST_DONE: ;
                default: ;
            endcase
        end
    end

    // Assertions.
    a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held longer than one cycle");
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted command did not raise busy");
    a_idle_no_block_mix: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.caller_blocked) |-> $past(cmd_reg.operation) == OP_P)
        else $error("blocked reported for non-P command");
    a_cfg_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy) else $error("config accepted while busy");
endmodule
